// ===== design/pfsrf_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsrf_pkg
// Shared types and codes for the per-flow sequence and rate filter.
// ----------------------------------------------------------------------------
package pfsrf_pkg;

  localparam int SEQ_W   = 32;
  localparam int TICK_W  = 64;
  localparam int SLOT_W  = 8;
  localparam int IVL_W   = 16;
  localparam int VERD_W  = 3;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [IVL_W-1:0] MIN_INTERVAL_RESET = 16'd45;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_LEAVE   = 1'b1;

  localparam logic [0:0] REG_MIN_INTERVAL = 1'b0;

  localparam logic [VERD_W-1:0] VERDICT_RELAYED = 3'd0;
  localparam logic [VERD_W-1:0] VERDICT_INVALID = 3'd1;
  localparam logic [VERD_W-1:0] VERDICT_STALE   = 3'd2;
  localparam logic [VERD_W-1:0] VERDICT_RATE    = 3'd3;
  localparam logic [VERD_W-1:0] VERDICT_CLEARED = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic commit;
  } cmd_t;

endpackage

// ===== design/pfsrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfsrf_ctrl
// Request sequencer: accept, compare, decide.
// ----------------------------------------------------------------------------
module pfsrf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output pfsrf_pkg::cmd_t cmd
);

  pfsrf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfsrf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      pfsrf_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = pfsrf_pkg::ST_CALC;
        end
      end
      pfsrf_pkg::ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = pfsrf_pkg::ST_DECIDE;
      end
      pfsrf_pkg::ST_DECIDE: begin
        cmd.commit = 1'b1;
        state_next = pfsrf_pkg::ST_IDLE;
      end
      default: begin
        state_next = pfsrf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pfsrf_datapath.sv =====
// ----------------------------------------------------------------------------
// pfsrf_datapath
// Slot table, sequence and interval checks, result registers.
// ----------------------------------------------------------------------------
module pfsrf_datapath #(
  parameter int PLAYER_SLOTS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pfsrf_pkg::cmd_t                    cmd,
  input  logic                               opcode,
  input  logic [pfsrf_pkg::SLOT_W-1:0]       player_slot,
  input  logic [pfsrf_pkg::SEQ_W-1:0]        sequence_req,
  input  logic [pfsrf_pkg::TICK_W-1:0]       now_tick,
  input  logic                               source_present,
  input  logic                               origin_valid,
  input  logic                               destination_valid,
  input  logic                               weapon_present,
  input  logic                               ammo_present,
  input  logic                               spell_present,
  input  logic                               power_positive,
  input  logic                               sun_gazing,
  input  logic [pfsrf_pkg::IVL_W-1:0]        min_interval,
  output logic                               done,
  output logic                               relay,
  output logic [pfsrf_pkg::VERD_W-1:0]       verdict
);

  localparam int DEPTH = (PLAYER_SLOTS < 256) ? PLAYER_SLOTS : 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENT_W = pfsrf_pkg::SEQ_W + pfsrf_pkg::TICK_W;
  localparam int CMP_W = 17;

  logic [ENT_W-1:0] entry_mem [DEPTH];
  logic             slot_valid [DEPTH];

  logic [IDX_W-1:0]                idx_in;
  logic                            in_range_in;

  logic                            op;
  logic [IDX_W-1:0]                idx;
  logic                            in_range;
  logic                            bad_req;
  logic [pfsrf_pkg::SEQ_W-1:0]     seq;
  logic [pfsrf_pkg::TICK_W-1:0]    now;
  logic                            hit;
  logic [ENT_W-1:0]                rd_entry;

  logic                            newer;
  logic                            tick_ge;
  logic                            last_nz;
  logic [pfsrf_pkg::TICK_W-1:0]    elapsed;

  logic [pfsrf_pkg::SEQ_W-1:0]     seq_diff;
  logic [pfsrf_pkg::TICK_W:0]      tick_diff;
  logic                            rate_hit;

  assign idx_in      = player_slot[IDX_W-1:0];
  assign in_range_in = {{(CMP_W-pfsrf_pkg::SLOT_W){1'b0}}, player_slot} < CMP_W'(PLAYER_SLOTS);

  // load: capture request, read slot entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= opcode;
      idx      <= idx_in;
      in_range <= in_range_in;
      seq      <= sequence_req;
      now      <= now_tick;
      bad_req  <= (sequence_req == '0) || !source_present ||
                  !(origin_valid | destination_valid | weapon_present | ammo_present |
                    spell_present | power_positive | sun_gazing) || !in_range_in;
      hit      <= in_range_in && slot_valid[idx_in];
      rd_entry <= entry_mem[idx_in];
    end
  end

  assign seq_diff  = seq - rd_entry[ENT_W-1 -: pfsrf_pkg::SEQ_W];
  assign tick_diff = {1'b0, now} - {1'b0, rd_entry[pfsrf_pkg::TICK_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      newer   <= (seq_diff != '0) && !seq_diff[pfsrf_pkg::SEQ_W-1];
      tick_ge <= !tick_diff[pfsrf_pkg::TICK_W];
      last_nz <= rd_entry[pfsrf_pkg::TICK_W-1:0] != '0;
      elapsed <= tick_diff[pfsrf_pkg::TICK_W-1:0];
    end
  end

  assign rate_hit = last_nz && tick_ge &&
                    (elapsed[pfsrf_pkg::TICK_W-1:pfsrf_pkg::IVL_W] == '0) &&
                    (elapsed[pfsrf_pkg::IVL_W-1:0] < min_interval);

  always_ff @(posedge clk) begin
    if (cmd.commit && op == pfsrf_pkg::OP_REQUEST && !bad_req && !(hit && (!newer || rate_hit)))
    begin
      entry_mem[idx] <= {seq, now};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else if (cmd.commit && in_range) begin
      if (op == pfsrf_pkg::OP_LEAVE) begin
        slot_valid[idx] <= 1'b0;
      end else if (!bad_req && !(hit && (!newer || rate_hit))) begin
        slot_valid[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      relay <= 1'b0;
      if (op == pfsrf_pkg::OP_LEAVE) begin
        verdict <= pfsrf_pkg::VERDICT_CLEARED;
      end else if (bad_req) begin
        verdict <= pfsrf_pkg::VERDICT_INVALID;
      end else if (hit && !newer) begin
        verdict <= pfsrf_pkg::VERDICT_STALE;
      end else if (hit && rate_hit) begin
        verdict <= pfsrf_pkg::VERDICT_RATE;
      end else begin
        verdict <= pfsrf_pkg::VERDICT_RELAYED;
        relay   <= 1'b1;
      end
    end
  end

endmodule

// ===== design/per_flow_sequence_rate_filter.sv =====
// ----------------------------------------------------------------------------
// per_flow_sequence_rate_filter
// Per-sender replay and rate filter with an APB register for the interval.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request passes
// through accept (with slot table read), sequence/tick compare, and decide
// (with table write-back); busy stays high through compare and decide, so a
// new request is not taken until the last one has been decided. The result
// (relay, verdict) is shown for exactly one cycle with done high, in the cycle
// after the decide step; there is no backpressure, so it must be captured
// that cycle. Slot valid bits clear at reset; no clearing pass is needed.
// min_interval_ms sits at byte address 0 and may be written only while idle.
module per_flow_sequence_rate_filter #(
  parameter int PLAYER_SLOTS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pfsrf_pkg::ADDR_W-1:0]        paddr,
  input  logic [pfsrf_pkg::DATA_W-1:0]        pwdata,
  output logic [pfsrf_pkg::DATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode,
  input  logic [pfsrf_pkg::SLOT_W-1:0]        player_slot,
  input  logic [pfsrf_pkg::SEQ_W-1:0]         sequence_req,
  input  logic [pfsrf_pkg::TICK_W-1:0]        now_tick,
  input  logic                                source_present,
  input  logic                                origin_valid,
  input  logic                                destination_valid,
  input  logic                                weapon_present,
  input  logic                                ammo_present,
  input  logic                                spell_present,
  input  logic                                power_positive,
  input  logic                                sun_gazing,
  output logic                                done,
  output logic                                relay,
  output logic [pfsrf_pkg::VERD_W-1:0]        verdict
);

  logic [pfsrf_pkg::IVL_W-1:0] min_interval_ms;
  pfsrf_pkg::cmd_t             cmd;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == pfsrf_pkg::REG_MIN_INTERVAL;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval_ms <= pfsrf_pkg::MIN_INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      min_interval_ms <= pwdata[pfsrf_pkg::IVL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(pfsrf_pkg::DATA_W-pfsrf_pkg::IVL_W){1'b0}}, min_interval_ms};
    end
  end

  pfsrf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  pfsrf_datapath #(
    .PLAYER_SLOTS (PLAYER_SLOTS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .opcode            (opcode),
    .player_slot       (player_slot),
    .sequence_req      (sequence_req),
    .now_tick          (now_tick),
    .source_present    (source_present),
    .origin_valid      (origin_valid),
    .destination_valid (destination_valid),
    .weapon_present    (weapon_present),
    .ammo_present      (ammo_present),
    .spell_present     (spell_present),
    .power_positive    (power_positive),
    .sun_gazing        (sun_gazing),
    .min_interval      (min_interval_ms),
    .done              (done),
    .relay             (relay),
    .verdict           (verdict)
  );

endmodule

// ===== verif/pfsrf_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsrf_verdict_checker
// Watches the request, result and register ports of the filter, keeps its own
// copy of the per-slot table and the interval, predicts the verdict of each
// accepted request and compares it with the strobed result, in order.
// ----------------------------------------------------------------------------
module pfsrf_verdict_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [pfsrf_pkg::ADDR_W-1:0]  paddr,
  input  logic [pfsrf_pkg::DATA_W-1:0]  pwdata,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          opcode,
  input  logic [pfsrf_pkg::SLOT_W-1:0]  player_slot,
  input  logic [pfsrf_pkg::SEQ_W-1:0]   sequence_req,
  input  logic [pfsrf_pkg::TICK_W-1:0]  now_tick,
  input  logic                          source_present,
  input  logic                          origin_valid,
  input  logic                          destination_valid,
  input  logic                          weapon_present,
  input  logic                          ammo_present,
  input  logic                          spell_present,
  input  logic                          power_positive,
  input  logic                          sun_gazing,
  input  logic                          done,
  input  logic                          relay,
  input  logic [pfsrf_pkg::VERD_W-1:0]  verdict,
  output int                            mismatches,
  output int                            pending
);

  typedef struct packed {
    logic                         relay;
    logic [pfsrf_pkg::VERD_W-1:0] verdict;
  } verdict_t;

  localparam logic [pfsrf_pkg::ADDR_W-1:0] MIN_INTERVAL_ADDR =
    pfsrf_pkg::ADDR_W'({pfsrf_pkg::REG_MIN_INTERVAL, 2'b00});

  logic [pfsrf_pkg::IVL_W-1:0]  min_gap;
  logic                         slot_live [256];
  logic [pfsrf_pkg::SEQ_W-1:0]  seq_held  [256];
  logic [pfsrf_pkg::TICK_W-1:0] tick_held [256];
  verdict_t                     expected_verdicts [$];
  int                           fail_count = 0;

  function automatic verdict_t judge_request(input logic op,
                                             input logic [pfsrf_pkg::SLOT_W-1:0] slot,
                                             input logic [pfsrf_pkg::SEQ_W-1:0] seq,
                                             input logic [pfsrf_pkg::TICK_W-1:0] tick,
                                             input logic src, input logic [6:0] intents);
    verdict_t                     r;
    logic [pfsrf_pkg::SEQ_W-1:0]  seq_step;
    logic [pfsrf_pkg::TICK_W-1:0] held;
    r.relay = 1'b0;
    if (op == pfsrf_pkg::OP_LEAVE) begin
      slot_live[slot] = 1'b0;
      r.verdict = pfsrf_pkg::VERDICT_CLEARED;
      return r;
    end
    if (seq == '0 || !src || intents == '0) begin
      r.verdict = pfsrf_pkg::VERDICT_INVALID;
      return r;
    end
    if (slot_live[slot]) begin
      seq_step = seq - seq_held[slot];
      held = tick_held[slot];
      // serial arithmetic: newer means a nonzero step below half the space
      if (seq_step == '0 || seq_step[pfsrf_pkg::SEQ_W-1]) begin
        r.verdict = pfsrf_pkg::VERDICT_STALE;
        return r;
      end
      if (held != '0 && tick >= held &&
          (tick - held) < pfsrf_pkg::TICK_W'(min_gap)) begin
        r.verdict = pfsrf_pkg::VERDICT_RATE;
        return r;
      end
    end
    seq_held[slot]  = seq;
    tick_held[slot] = tick;
    slot_live[slot] = 1'b1;
    r.relay = 1'b1;
    r.verdict = pfsrf_pkg::VERDICT_RELAYED;
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      min_gap = pfsrf_pkg::MIN_INTERVAL_RESET;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (done) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result relay=%0d verdict=%0d", $time, relay, verdict);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (relay !== want.relay) begin
            $display("%0t: relay mismatch, expected %0d, actual %0d",
                     $time, want.relay, relay);
            fail_count++;
          end
          if (verdict !== want.verdict) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d",
                     $time, want.verdict, verdict);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == MIN_INTERVAL_ADDR)
        min_gap = pwdata[pfsrf_pkg::IVL_W-1:0];
      if (start && !busy)
        expected_verdicts.push_back(judge_request(opcode, player_slot, sequence_req, now_tick,
                                                  source_present,
                                                  {origin_valid, destination_valid,
                                                   weapon_present, ammo_present,
                                                   spell_present, power_positive,
                                                   sun_gazing}));
    end
    mismatches <= fail_count;
    pending    <= expected_verdicts.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sequence and rate filter: a directed pass over invalid, stale,
// rate-limited, wrap-around and leave requests, then random request streams
// per slot under several interval settings with random sender gaps.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [pfsrf_pkg::ADDR_W-1:0] MIN_INTERVAL_ADDR =
    pfsrf_pkg::ADDR_W'({pfsrf_pkg::REG_MIN_INTERVAL, 2'b00});
  localparam logic [pfsrf_pkg::ADDR_W-1:0] UNUSED_ADDR =
    MIN_INTERVAL_ADDR + pfsrf_pkg::ADDR_W'(4);

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         psel, penable, pwrite, pready;
  logic [pfsrf_pkg::ADDR_W-1:0] paddr;
  logic [pfsrf_pkg::DATA_W-1:0] pwdata, prdata;
  logic                         start, busy, done, relay;
  logic                         opcode;
  logic [pfsrf_pkg::SLOT_W-1:0] player_slot;
  logic [pfsrf_pkg::SEQ_W-1:0]  sequence_req;
  logic [pfsrf_pkg::TICK_W-1:0] now_tick;
  logic                         source_present, origin_valid, destination_valid;
  logic                         weapon_present, ammo_present, spell_present;
  logic                         power_positive, sun_gazing;
  logic [pfsrf_pkg::VERD_W-1:0] verdict;
  int                           mismatches, pending;

  logic [pfsrf_pkg::SEQ_W-1:0]  next_seq [256];
  logic [pfsrf_pkg::TICK_W-1:0] cur_tick;
  int unsigned                  ivl_now;

  always #5 clk = ~clk;

  per_flow_sequence_rate_filter u_top (.*);

  pfsrf_verdict_checker u_checker (.*);

  task automatic drive_request(input logic op, input logic [pfsrf_pkg::SLOT_W-1:0] slot,
                               input logic [pfsrf_pkg::SEQ_W-1:0] seq,
                               input logic [pfsrf_pkg::TICK_W-1:0] tick,
                               input logic src, input logic [6:0] intents);
    start          <= 1'b1;
    opcode         <= op;
    player_slot    <= slot;
    sequence_req   <= seq;
    now_tick       <= tick;
    source_present <= src;
    {origin_valid, destination_valid, weapon_present, ammo_present,
     spell_present, power_positive, sun_gazing} <= intents;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_idle(input bit steady);
    if (!steady && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // hold requests until every verdict is back
  task automatic settle;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pfsrf_pkg::ADDR_W-1:0] addr,
                           input logic [pfsrf_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [pfsrf_pkg::SLOT_W-1:0] pick_slot;
    int unsigned idx;
    idx = $urandom_range(7);
    if ($urandom_range(99) < 75) begin
      return (idx < 4) ? pfsrf_pkg::SLOT_W'(idx) : pfsrf_pkg::SLOT_W'(248 + idx);
    end
    return pfsrf_pkg::SLOT_W'($urandom_range(255));
  endfunction

  task automatic random_request(input bit steady);
    int unsigned                  r, q, t;
    logic [pfsrf_pkg::SLOT_W-1:0] slot;
    logic [pfsrf_pkg::SEQ_W-1:0]  seq_step;
    r = $urandom_range(99);
    slot = pick_slot();
    if (r < 8) begin
      drive_request(pfsrf_pkg::OP_LEAVE, slot, $urandom, {$urandom, $urandom},
                    1'($urandom), 7'($urandom));
    end else if (r < 18) begin
      drive_request(pfsrf_pkg::OP_REQUEST, pfsrf_pkg::SLOT_W'($urandom_range(255)),
                    ($urandom_range(3) == 0) ? '0 : pfsrf_pkg::SEQ_W'($urandom),
                    {$urandom, $urandom}, 1'($urandom), 7'($urandom));
    end else begin
      q = $urandom_range(99);
      if (q < 80)      seq_step = pfsrf_pkg::SEQ_W'($urandom_range(1, 4));
      else if (q < 88) seq_step = '0;
      else if (q < 94) seq_step = 32'h8000_0000 + pfsrf_pkg::SEQ_W'($urandom_range(0, 3));
      else             seq_step = $urandom;
      next_seq[slot] = next_seq[slot] + seq_step;
      t = $urandom_range(99);
      if (t < 4)       cur_tick = '0;
      else if (t < 9)  cur_tick = {$urandom, $urandom};
      else if (t < 14) cur_tick = cur_tick - pfsrf_pkg::TICK_W'($urandom_range(1, 50));
      else cur_tick = cur_tick + pfsrf_pkg::TICK_W'($urandom_range(0, ivl_now / 2 + 2));
      drive_request(pfsrf_pkg::OP_REQUEST, slot, next_seq[slot], cur_tick, 1'b1,
                    7'($urandom_range(1, 127)));
    end
    maybe_idle(steady);
  endtask

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [pfsrf_pkg::IVL_W-1:0] phase_gap [5];
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    start          <= 1'b0;
    opcode         <= pfsrf_pkg::OP_REQUEST;
    player_slot    <= '0;
    sequence_req   <= '0;
    now_tick       <= '0;
    source_present <= 1'b0;
    {origin_valid, destination_valid, weapon_present, ammo_present,
     spell_present, power_positive, sun_gazing} <= '0;
    foreach (next_seq[i]) next_seq[i] = $urandom;
    cur_tick = pfsrf_pkg::TICK_W'($urandom_range(1000, 5000));
    ivl_now = 32'(pfsrf_pkg::MIN_INTERVAL_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // invalid: zero sequence, no source, no intent
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd10, 32'd0, 64'd50, 1'b1, 7'h7F);
    maybe_idle(1'b0);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd10, 32'd1, 64'd50, 1'b0, 7'h7F);
    maybe_idle(1'b0);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd10, 32'd1, 64'd50, 1'b1, 7'h00);
    maybe_idle(1'b0);
    // each intent flag alone relays
    for (int i = 0; i < 7; i++) begin
      drive_request(pfsrf_pkg::OP_REQUEST, pfsrf_pkg::SLOT_W'(i + 1), 32'd1, 64'd100,
                    1'b1, 7'(1 << i));
      maybe_idle(1'b0);
    end
    // interval boundary, then half-range sequence step still newer
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd1, 32'd2, 64'd144, 1'b1, 7'h01);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd1, 32'd3, 64'd145, 1'b1, 7'h01);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd2, 32'h8000_0000, 64'd300, 1'b1, 7'h40);
    maybe_idle(1'b0);
    // wrap of sequence and tick, tick behind, stored tick of zero
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd255, 32'hFFFF_FFFF, '1, 1'b1, 7'h7F);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd255, 32'd1, '1, 1'b1, 7'h7F);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd255, 32'd2, 64'd0, 1'b1, 7'h7F);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd255, 32'd3, 64'd1, 1'b1, 7'h7F);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd255, 32'd3, 64'd100, 1'b1, 7'h7F);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd255, 32'h8000_0003, 64'd500, 1'b1, 7'h7F);
    maybe_idle(1'b0);
    // leave, then a request on the cleared slot skips the checks
    drive_request(pfsrf_pkg::OP_LEAVE, 8'd255, $urandom, {$urandom, $urandom}, 1'b1, 7'h7F);
    drive_request(pfsrf_pkg::OP_REQUEST, 8'd255, 32'd1, 64'd5, 1'b1, 7'h01);
    drive_request(pfsrf_pkg::OP_LEAVE, 8'd0, 32'd0, 64'd0, 1'b0, 7'h00);
    settle();

    write_reg(UNUSED_ADDR, $urandom);
    phase_gap = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), pfsrf_pkg::MIN_INTERVAL_RESET};
    for (int p = 0; p < 5; p++) begin
      write_reg(MIN_INTERVAL_ADDR, {16'($urandom), phase_gap[p]});
      ivl_now = 32'(phase_gap[p]);
      for (int n = 0; n < 80; n++) begin
        random_request(p == 1 && n < 60);
        if (p == 2 && n == 40) settle();
      end
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
